FILE: src/escape_sequence_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Clocked assertion, ignored while reset is held.
`define ESD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define ESD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/esd_pkg.sv
package esd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       run_last;
    } out_word_t;

    // Result kinds
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_UNTERM  = 3'd2;
    localparam logic [2:0] KIND_BADHEX  = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    // Decoder modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_HEX1   = 3'd2;
    localparam logic [2:0] MODE_HEX2   = 3'd3;
    localparam logic [2:0] MODE_DROP   = 3'd4;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Results handed from the decoder to the result queue
    typedef struct packed {
        logic [1:0] count;
        out_word_t  res0;
        out_word_t  res1;
    } push_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

FILE: src/esd_decode.sv
module esd_decode
    import esd_pkg::*;
(
    input  logic [2:0] mode,
    input  logic [3:0] nibble,
    input  in_word_t   word,
    output logic [2:0] mode_next,
    output logic [3:0] nibble_next,
    output push_t      push
);

    logic       fin;
    logic [7:0] b;
    logic [4:0] hex;
    logic       do_data;
    logic [7:0] data_byte;
    logic       do_fail;
    logic [7:0] fail_byte;
    logic [2:0] fail_kind;
    logic       to_esc;
    logic       to_hex1;
    logic       to_hex2;
    logic       to_normal;

    assign fin = word.is_final;
    assign b   = word.in_byte;
    assign hex = hex_value(b);

    always_comb begin
        do_data   = 1'b0;
        data_byte = b;
        do_fail   = 1'b0;
        fail_byte = 8'd0;
        fail_kind = KIND_BADHEX;
        to_esc    = 1'b0;
        to_hex1   = 1'b0;
        to_hex2   = 1'b0;
        to_normal = 1'b0;
        unique case (mode)
            MODE_ESC: begin
                unique case (b)
                    8'h5C: begin do_data = 1'b1; data_byte = 8'h5C; end
                    8'h22: begin do_data = 1'b1; data_byte = 8'h22; end
                    8'h6E: begin do_data = 1'b1; data_byte = 8'h0A; end
                    8'h72: begin do_data = 1'b1; data_byte = 8'h0D; end
                    8'h74: begin do_data = 1'b1; data_byte = 8'h09; end
                    8'h30: begin do_data = 1'b1; data_byte = 8'h00; end
                    8'h78: begin
                        if (fin) do_fail = 1'b1;
                        else     to_hex1 = 1'b1;
                    end
                    default: begin
                        do_fail   = 1'b1;
                        fail_byte = b;
                        fail_kind = KIND_UNKNOWN;
                    end
                endcase
            end
            MODE_HEX1: begin
                if (!hex[4] || fin) do_fail = 1'b1;
                else                to_hex2 = 1'b1;
            end
            MODE_HEX2: begin
                if (!hex[4]) begin
                    do_fail = 1'b1;
                end else begin
                    do_data   = 1'b1;
                    data_byte = {nibble, hex[3:0]};
                end
            end
            MODE_DROP: begin
                to_normal = fin;
            end
            default: begin
                if (b == 8'h5C) begin
                    if (fin) begin
                        do_fail   = 1'b1;
                        fail_kind = KIND_UNTERM;
                    end else begin
                        to_esc = 1'b1;
                    end
                end else begin
                    do_data = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        mode_next   = mode;
        nibble_next = nibble;
        push.count  = 2'd0;
        push.res0   = '{out_byte: data_byte, kind: KIND_DATA, run_last: fin};
        push.res1   = '{out_byte: 8'd0, kind: KIND_OK, run_last: 1'b1};
        if (do_data) begin
            mode_next  = MODE_NORMAL;
            push.count = fin ? 2'd2 : 2'd1;
            push.res0.run_last = !fin;
        end else if (do_fail) begin
            mode_next  = fin ? MODE_NORMAL : MODE_DROP;
            push.count = 2'd1;
            push.res0  = '{out_byte: fail_byte, kind: fail_kind, run_last: 1'b1};
        end else if (to_esc) begin
            mode_next = MODE_ESC;
        end else if (to_hex1) begin
            mode_next = MODE_HEX1;
        end else if (to_hex2) begin
            mode_next   = MODE_HEX2;
            nibble_next = hex[3:0];
        end else if (to_normal) begin
            mode_next = MODE_NORMAL;
        end
    end

endmodule

FILE: src/esd_res_queue.sv
module esd_res_queue
    import esd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  push_t     push,
    output logic      room2,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    out_word_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               pop;

    assign m_valid = (count_reg != '0);
    assign m_word  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign room2   = (count_reg <= QCNT_W'(QDEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            slot_reg[wr_ptr_reg + QPTR_W'(1)] <= push.res1;
        end
    end

endmodule

FILE: src/escape_sequence_decoder.sv
// Escaped string literal decoder.
// Input channel (s_valid/s_ready/s_word): one raw byte per word, with
// is_final set on the last byte of each literal.
// Result channel (m_valid/m_ready/m_word): decoded data bytes (kind data)
// and exactly one end word per literal (success, unterminated escape, bad
// hex escape, or unknown escape carrying the offending character).
// run_last marks the last result caused by one input byte.
// Throughput: one input byte per cycle while s_ready is high. A final
// byte that completes data makes two results; the four-entry result queue
// absorbs an isolated one, while back-to-back ones stall the input.
// With the queue empty, a result is on m_word in the cycle after its
// byte is accepted. s_ready is high while the queue has room for two
// results; it does not depend on s_valid.
// Receiver stall: results wait in the queue; input stops once fewer than
// two slots are free, and resumes as soon as the queue is back down to
// two words.
// Reset (aresetn low, synchronous): the queue empties, decoding returns to
// normal copying and any pending escape is forgotten.
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    // Escape state: mode and the first hex digit of a pending \x escape.
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;
    logic       accept;
    push_t      dec_push;
    push_t      q_push;

    assign accept = s_valid && s_ready;

    // Single-pass decode of the incoming word against the current state.
    esd_decode u_decode (
        .mode        (mode_reg),
        .nibble      (nibble_reg),
        .word        (s_word),
        .mode_next   (mode_next),
        .nibble_next (nibble_next),
        .push        (dec_push)
    );

    // Only an accepted word writes results into the queue.
    always_comb begin
        q_push = dec_push;
        if (!accept) begin
            q_push.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            nibble_reg <= 4'd0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
        end
    end

    // Result register stage: small queue that decouples the two channels.
    esd_res_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .room2   (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

FILE: src/esd_checker.sv
`include "escape_sequence_decoder_defines.svh"

module esd_checker
    import esd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    logic stall;
    logic plain_end;
    logic plain_ok;
    logic unknown_end;

    assign stall       = m_valid && !m_ready;
    // end words that carry no byte
    assign plain_end   = m_valid && (m_word.kind == KIND_OK || m_word.kind == KIND_UNTERM ||
                                     m_word.kind == KIND_BADHEX);
    assign plain_ok    = m_word.run_last && (m_word.out_byte == 8'd0);
    assign unknown_end = m_valid && (m_word.kind == KIND_UNKNOWN);

    `ESD_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> !m_valid && s_ready, "reset state")
    `ESD_ASSERT(a_hold, aclk, aresetn, stall |=> m_valid && $stable(m_word), "stalled word changed")
    `ESD_ASSERT(a_end_word, aclk, aresetn, plain_end |-> plain_ok, "bad end word")
    `ESD_ASSERT(a_unknown_last, aclk, aresetn, unknown_end |-> m_word.run_last, "unknown not last")

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    // ------------------------------------------------------------------
    // Character codes used by the escape syntax
    // ------------------------------------------------------------------
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    localparam out_word_t NO_RES = '0;

    // Receiver hold-off: starts once this many words went in, lasts this long
    localparam int HOLD_AT  = 600;
    localparam int HOLD_LEN = 60;

    // Random live words (outside drop tails) per idle phase (three phases)
    localparam int WORDS_PER_PHASE = 250;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    escape_sequence_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Directed table. Rows with typed set carry the expected words;
    // the rest are left to the decoder model below.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
        logic       typed;
        logic [1:0] n_res;
        out_word_t  res0;
        out_word_t  res1;
    } dir_row_t;

    localparam int N_DIR = 25;

    dir_row_t dir_rows [N_DIR] = '{
        // plain bytes, extremes; 0xFF closes the literal -> data + OK
        '{8'h41, 1'b0, 1'b1, 2'd1, '{8'h41, KIND_DATA, 1'b1}, NO_RES},
        '{8'hFF, 1'b1, 1'b1, 2'd2, '{8'hFF, KIND_DATA, 1'b0}, '{8'h00, KIND_OK, 1'b1}},
        // lone backslash on the final byte
        '{CH_BSLASH, 1'b1, 1'b1, 2'd1, '{8'h00, KIND_UNTERM, 1'b1}, NO_RES},
        // simple escapes, literal closed by an escaped quote
        '{CH_BSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_N,      1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_T,      1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_QUOTE,  1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        // x on the final byte
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,      1'b1, 1'b1, 2'd1, '{8'h00, KIND_BADHEX, 1'b1}, NO_RES},
        // x plus one digit on the final byte
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,      1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h35,     1'b1, 1'b1, 2'd1, '{8'h00, KIND_BADHEX, 1'b1}, NO_RES},
        // non-hex where a digit is due, then drop until final
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,      1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h67,     1'b0, 1'b1, 2'd1, '{8'h00, KIND_BADHEX, 1'b1}, NO_RES},
        '{8'h71,     1'b1, 1'b1, 2'd0, NO_RES, NO_RES},
        // mixed-case hex escape closing the literal
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_X,      1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_UC_F,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_LC_A,   1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        // unknown escape carries the char, final byte of dropped tail gives nothing
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h7E,     1'b0, 1'b1, 2'd1, '{8'h7E, KIND_UNKNOWN, 1'b1}, NO_RES},
        '{8'h00,     1'b1, 1'b1, 2'd0, NO_RES, NO_RES}
    };

    logic [7:0] simple_esc [6] = '{CH_BSLASH, CH_QUOTE, CH_N, CH_R, CH_T, CH_ZERO};

    // ------------------------------------------------------------------
    // Decoder model state and bookkeeping
    // ------------------------------------------------------------------
    logic [2:0] dec_mode   = MODE_NORMAL;
    logic [3:0] dec_nibble = 4'd0;
    out_word_t  step_words [$];     // words caused by the byte just decoded
    out_word_t  pending_words [$];  // words still owed by the DUT

    int s_idle_pct  = 9;
    int m_idle_pct  = 76;
    int n_accepted  = 0;
    int n_live      = 0;   // accepted bytes that were not in the drop tail
    int n_errors    = 0;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 4'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            v = 4'(c - CH_LC_A + 8'd10);
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            v = 4'(c - CH_UC_A + 8'd10);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void put_word(input logic [7:0] b, input logic [2:0] k);
        out_word_t w;
        w.out_byte = b;
        w.kind     = k;
        w.run_last = 1'b0;
        step_words = {step_words, w};
    endfunction

    // data byte, plus the success end when it closes the literal
    function automatic void emit_data(input logic [7:0] b, input logic fin);
        put_word(b, KIND_DATA);
        if (fin) begin
            put_word(8'h00, KIND_OK);
        end
        dec_mode = MODE_NORMAL;
    endfunction

    // error end; the rest of the literal is dropped unless this was its end
    function automatic void emit_error(input logic [7:0] b, input logic [2:0] k,
                                       input logic fin);
        put_word(b, k);
        dec_mode = fin ? MODE_NORMAL : MODE_DROP;
    endfunction

    function automatic void decode_byte(input in_word_t w);
        logic [7:0] b;
        logic       fin;
        logic [3:0] v;
        bit         ok;
        b   = w.in_byte;
        fin = w.is_final;
        step_words.delete();
        case (dec_mode)
            MODE_ESC: begin
                case (b)
                    CH_BSLASH: emit_data(CH_BSLASH, fin);
                    CH_QUOTE:  emit_data(CH_QUOTE, fin);
                    CH_N:      emit_data(8'h0A, fin);
                    CH_R:      emit_data(8'h0D, fin);
                    CH_T:      emit_data(8'h09, fin);
                    CH_ZERO:   emit_data(8'h00, fin);
                    CH_X: begin
                        if (fin) emit_error(8'h00, KIND_BADHEX, fin);
                        else     dec_mode = MODE_HEX1;
                    end
                    default:   emit_error(b, KIND_UNKNOWN, fin);
                endcase
            end
            MODE_HEX1: begin
                ok = hex_nibble(b, v);
                if (!ok || fin) begin
                    emit_error(8'h00, KIND_BADHEX, fin);
                end else begin
                    dec_nibble = v;
                    dec_mode   = MODE_HEX2;
                end
            end
            MODE_HEX2: begin
                ok = hex_nibble(b, v);
                if (!ok) emit_error(8'h00, KIND_BADHEX, fin);
                else     emit_data({dec_nibble, v}, fin);
            end
            MODE_DROP: begin
                if (fin) dec_mode = MODE_NORMAL;
            end
            default: begin
                if (b == CH_BSLASH) begin
                    if (fin) emit_error(8'h00, KIND_UNTERM, fin);
                    else     dec_mode = MODE_ESC;
                end else begin
                    emit_data(b, fin);
                end
            end
        endcase
        if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].run_last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle gap, then hold valid until accepted. Inputs
    // change only at the falling edge; the task returns on a falling edge.
    // n_typed < 0 means the model supplies the expected words.
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t w, input int n_typed,
                             input out_word_t t0, input out_word_t t1);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        // accepted on this edge
        n_accepted++;
        if (dec_mode != MODE_DROP) n_live++;
        decode_byte(w);
        if (n_typed < 0) begin
            pending_words = {pending_words, step_words};
        end else begin
            if (n_typed > 0) pending_words = {pending_words, t0};
            if (n_typed > 1) pending_words = {pending_words, t1};
        end
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Random literal builder
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + 8'(d) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] v;
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c, v));
        return c;
    endfunction

    task automatic send_literal();
        logic [7:0] bytes [$];
        logic [7:0] c;
        in_word_t   w;
        int         n_tok;
        int         pick;
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                // plain byte, anything but a backslash
                do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
                bytes = {bytes, c};
            end else if (pick < 66) begin
                bytes = {bytes, CH_BSLASH, simple_esc[$urandom_range(0, 5)]};
            end else if (pick < 84) begin
                bytes = {bytes, CH_BSLASH, CH_X};
                bytes = {bytes, hex_char(4'($urandom_range(0, 15)))};
                bytes = {bytes, hex_char(4'($urandom_range(0, 15)))};
            end else if (pick < 88) begin
                // unknown escape
                bytes = {bytes, CH_BSLASH};
                do c = 8'($urandom_range(0, 255));
                while (c == CH_X || c inside {CH_BSLASH, CH_QUOTE, CH_N, CH_R, CH_T, CH_ZERO});
                bytes = {bytes, c};
            end else if (pick < 91) begin
                // bad first hex digit
                bytes = {bytes, CH_BSLASH, CH_X, non_hex_char()};
            end else if (pick < 94) begin
                // bad second hex digit
                bytes = {bytes, CH_BSLASH, CH_X};
                bytes = {bytes, hex_char(4'($urandom_range(0, 15)))};
                bytes = {bytes, non_hex_char()};
            end else begin
                // raw noise, backslash included
                bytes = {bytes, 8'($urandom_range(0, 255))};
            end
        end
        // sometimes cut the literal off inside an escape
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            bytes = {bytes, CH_BSLASH};
        end else if (pick < 7) begin
            bytes = {bytes, CH_BSLASH, CH_X};
        end else if (pick < 10) begin
            bytes = {bytes, CH_BSLASH, CH_X};
            bytes = {bytes, hex_char(4'($urandom_range(0, 15)))};
        end
        foreach (bytes[i]) begin
            w.in_byte  = bytes[i];
            w.is_final = (i == bytes.size() - 1);
            send_word(w, -1, NO_RES, NO_RES);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off once enough
    // words went in, so the result queue fills and s_ready drops.
    // ------------------------------------------------------------------
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_LEN - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_words
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: unexpected word byte=%02h kind=%0d last=%0b",
                             $realtime, m_word.out_byte, m_word.kind, m_word.run_last);
            end else begin
                e = pending_words.pop_front();
                if (m_word.out_byte !== e.out_byte || m_word.kind !== e.kind ||
                    m_word.run_last !== e.run_last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: exp %02h/%0d/%0b got %02h/%0d/%0b",
                                 $realtime, e.out_byte, e.kind, e.run_last,
                                 m_word.out_byte, m_word.kind, m_word.run_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #400_000;
        $display("** escape_sequence_decoder: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        in_word_t w;
        int       drain;
        aclk    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word  = '0;
        m_ready = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, first idle phase: sender rarely idle, receiver mostly
        for (int i = 0; i < N_DIR; i++) begin
            w.in_byte  = dir_rows[i].in_byte;
            w.is_final = dir_rows[i].is_final;
            send_word(w, dir_rows[i].typed ? int'(dir_rows[i].n_res) : -1,
                      dir_rows[i].res0, dir_rows[i].res1);
        end

        // random literals over three idle phases
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin s_idle_pct = 9;  m_idle_pct = 76; end
                1: begin s_idle_pct = 76; m_idle_pct = 9;  end
                default: begin s_idle_pct = 0; m_idle_pct = 0; end
            endcase
            while (n_live < N_DIR + (ph + 1) * WORDS_PER_PHASE) send_literal();
        end
        s_valid <= 1'b0;

        // let the last words drain, then wait quietly for strays
        drain = 0;
        while (pending_words.size() > 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (10) @(posedge aclk);

        if (n_errors == 0 && pending_words.size() == 0) begin
            $display("** escape_sequence_decoder: PASSED **");
        end else begin
            $display("** escape_sequence_decoder: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/esd_pkg.sv
src/esd_decode.sv
src/esd_res_queue.sv
src/escape_sequence_decoder.sv
src/esd_checker.sv
sim/testbench.sv
